// File: sv/deq_pkg.sv
// shared types and codes for the double-ended queue
// operation kinds, status codes, controller states and the cell control group
// no dependencies
package deq_pkg;

   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      KIND_PUSH_LEFT  = 2'd0,
      KIND_PUSH_RIGHT = 2'd1,
      KIND_POP_LEFT   = 2'd2,
      KIND_POP_RIGHT  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_WAIT = 1'b1
   } state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic shl;      // every cell takes its right neighbor
      logic shr;      // every cell takes its left neighbor
      logic wr_end;   // the cell at pos takes the pushed word
      logic rd_end;   // the cell at pos puts its word on the return line
   } ctl_type;

endpackage

// File: sv/deq_cell.sv
// one storage cell of the deque chain: one word plus one return-line stage
// depends on deq_pkg for the control group type
module deq_cell
   import deq_pkg::*;
#(
   parameter int IDX_W = 4,
   parameter int IDX   = 0
) (
   input  logic              clock,
   input  ctl_type           ctl,
   input  logic [IDX_W-1:0]  pos,
   input  logic [WORD_W-1:0] wr_word,
   input  logic [WORD_W-1:0] left_data,
   input  logic [WORD_W-1:0] right_data,
   input  logic [WORD_W-1:0] right_ret,
   output logic [WORD_W-1:0] data_out,
   output logic [WORD_W-1:0] ret_out
);

   logic [WORD_W-1:0] data_ff, data_in;
   logic [WORD_W-1:0] ret_ff, ret_in;
   logic              here;

   assign here = (pos == IDX_W'(IDX));

   always_comb begin
      if (ctl.shr) begin
         data_in = left_data;
      end else if (ctl.shl) begin
         data_in = right_data;
      end else if (ctl.wr_end && here) begin
         data_in = wr_word;
      end else begin
         data_in = data_ff;
      end
   end

   // return line walks one cell toward the left end per cycle
   assign ret_in = (ctl.rd_end && here) ? data_ff : right_ret;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      ret_ff  <= ret_in;
   end

   assign data_out = data_ff;
   assign ret_out  = ret_ff;

endmodule

// File: sv/deq_ctrl.sv
// deque controller: occupancy, chain control, right-pop wait and result register
// depends on deq_pkg for kinds, status codes, states and the control group
module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  kind_type          kind,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [WORD_W-1:0] rsp_popped,
   output status_type        rsp_status,
   output logic [CNT_W-1:0]  rsp_occ,
   input  logic [WORD_W-1:0] head_word,
   input  logic [WORD_W-1:0] ret_word,
   output ctl_type           ctl,
   output logic [IDX_W-1:0]  pos
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  wait_cnt_ff, wait_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_popped_ff, rsp_popped_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic              accept, full, empty, wait_done, load;
   logic              is_push, pop_right_ok;
   logic [CNT_W-1:0]  cnt_dec;

   assign accept   = req_tvalid && req_tready;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign cnt_dec  = count_ff - CNT_W'(1);
   assign is_push  = (kind == KIND_PUSH_LEFT) || (kind == KIND_PUSH_RIGHT);
   assign pop_right_ok = (kind == KIND_POP_RIGHT) && !empty;
   assign wait_done = (state_ff == ST_WAIT) && (wait_cnt_ff == '0) && !rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && pop_right_ok) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (wait_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs to the request side and the chain
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
      ctl        = '0;
      pos        = (kind == KIND_POP_RIGHT) ? cnt_dec[IDX_W-1:0] : count_ff[IDX_W-1:0];
      if (accept) begin
         unique case (kind)
            KIND_PUSH_LEFT:  ctl.shr    = !full;
            KIND_PUSH_RIGHT: ctl.wr_end = !full;
            KIND_POP_LEFT:   ctl.shl    = !empty;
            KIND_POP_RIGHT:  ctl.rd_end = !empty;
            default:         ctl        = '0;
         endcase
      end
   end

   // occupancy, wait counter and result register
   always_comb begin
      count_in      = count_ff;
      wait_cnt_in   = wait_cnt_ff;
      load          = 1'b0;
      rsp_popped_in = rsp_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      if (accept) begin
         if (is_push) begin
            if (!full) count_in = count_ff + CNT_W'(1);
         end else if (!empty) begin
            count_in = cnt_dec;
         end
         wait_cnt_in = pos;
         if (!pop_right_ok) begin
            load          = 1'b1;
            rsp_popped_in = ((kind == KIND_POP_LEFT) && !empty) ? head_word : '0;
            rsp_occ_in    = count_in;
            if (is_push && full) begin
               rsp_status_in = STATUS_OVERFLOW;
            end else if (!is_push && empty) begin
               rsp_status_in = STATUS_UNDERFLOW;
            end else begin
               rsp_status_in = STATUS_OK;
            end
         end
      end else if (state_ff == ST_WAIT) begin
         if (wait_done) begin
            load          = 1'b1;
            rsp_popped_in = ret_word;
            rsp_status_in = STATUS_OK;
            rsp_occ_in    = count_ff;
         end else if (wait_cnt_ff != '0) begin
            wait_cnt_in = wait_cnt_ff - IDX_W'(1);
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wait_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_cnt_ff  <= wait_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_popped = rsp_popped_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_occ    = rsp_occ_ff;

endmodule

// File: sv/double_ended_queue.sv
// top level of the bounded double-ended queue: a chain of DEPTH cells and its controller
// depends on deq_pkg, deq_cell and deq_ctrl
//
//  channel  direction  handshake               payload
//  req      in         req_tvalid/req_tready   tuser: kind; tdata: value
//  rsp      out        rsp_tvalid/rsp_tready   tuser: status; tdata: popped, occupancy
//
// the left end sits at cell 0; push left and pop left shift the whole chain at once
// push left, push right, pop left and refused operations load the result register when accepted
// pop right waits while the word walks the return line from the end cell to cell 0
// reset clears occupancy, controller state and the result valid; cell words are not cleared
// a stalled result holds its register; a new transaction is taken when that register frees
module double_ended_queue
   import deq_pkg::*;
#(
   parameter  int DEPTH = 16,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int RSP_W = ((WORD_W + CNT_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] value
   input  logic [1:0]        req_tuser,   // [1:0] kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // [31:0] popped, then occupancy, zero fill
   output logic [1:0]        rsp_tuser    // [1:0] status
);

   ctl_type           ctl;
   logic [IDX_W-1:0]  pos;
   logic [WORD_W-1:0] data_w [DEPTH];
   logic [WORD_W-1:0] ret_w  [DEPTH];
   logic [WORD_W-1:0] rsp_popped;
   status_type        rsp_status;
   logic [CNT_W-1:0]  rsp_occ;

   deq_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (kind_type'(req_tuser)),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_popped (rsp_popped),
      .rsp_status (rsp_status),
      .rsp_occ    (rsp_occ),
      .head_word  (data_w[0]),
      .ret_word   (ret_w[0]),
      .ctl        (ctl),
      .pos        (pos)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_data, right_data, right_ret;

      if (i == 0) begin : g_left
         assign left_data = req_tdata;
      end else begin : g_mid_l
         assign left_data = data_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_right
         assign right_data = data_w[i];
         assign right_ret  = '0;
      end else begin : g_mid_r
         assign right_data = data_w[i+1];
         assign right_ret  = ret_w[i+1];
      end

      deq_cell #(
         .IDX_W (IDX_W),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (pos),
         .wr_word    (req_tdata),
         .left_data  (left_data),
         .right_data (right_data),
         .right_ret  (right_ret),
         .data_out   (data_w[i]),
         .ret_out    (ret_w[i])
      );
   end

   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[WORD_W-1:0]      = rsp_popped;
      rsp_tdata[WORD_W +: CNT_W] = rsp_occ;
   end

   assign rsp_tuser = rsp_status;

endmodule

// File: tb/double_ended_queue_tb.sv
// self-checking testbench for the bounded double-ended queue
// directed table, then long random operation sequences against a ring-buffer predictor
// depends on deq_pkg and double_ended_queue
`timescale 1ns / 100ps

module double_ended_queue_tb;
   import deq_pkg::*;

   localparam int DEPTH         = 16;
   localparam int CNT_W         = 5;
   localparam int RSP_W         = ((WORD_W + CNT_W + 7) / 8) * 8;
   localparam int RANDOM_OPS    = 1400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic [WORD_W-1:0] popped;
      status_type        status;
      logic [CNT_W-1:0]  occupancy;
   } deque_result_type;

   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] word;
      logic              typed;   // want holds a hand-written expectation
      deque_result_type  want;
   } op_row_type;

   typedef enum {RX_STEADY, RX_SPARSE, RX_BURSTY, RX_COIN} rx_mode_type;
   typedef enum {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED, SEQ_ANY} op_seq_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata  = '0;   // [31:0] value
   logic [1:0]        req_tuser  = '0;   // [1:0] kind
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;         // [31:0] popped, [36:32] occupancy, zero fill
   logic [1:0]        rsp_tuser;         // [1:0] status

   // travels beside the request so the monitor sees the typed expectation of that transaction
   logic              fixed_on     = 1'b0;
   deque_result_type  fixed_result = '0;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ring-buffer mirror of the deque
   logic [WORD_W-1:0] mirror_words [DEPTH];
   logic [3:0]        left_pos     = '0;
   logic [3:0]        right_pos    = '0;
   logic [CNT_W-1:0]  mirror_count = '0;

   deque_result_type pending_results[$];
   op_row_type       directed_rows[$];
   int               sent_count   = 0;
   int               got_count    = 0;
   int               mismatches   = 0;
   int               cycle_count  = 0;
   int               burst_left   = 0;
   int               plan_count   = 0;   // occupancy as seen by the sender
   rx_mode_type      rx_mode      = RX_STEADY;
   int               rx_mode_left = 0;
   int               rx_stall     = 0;

   task automatic apply_deque_op(input kind_type k, input logic [WORD_W-1:0] w,
                                 output deque_result_type r);
      r.popped = '0;
      r.status = STATUS_OK;
      if (k == KIND_PUSH_LEFT || k == KIND_PUSH_RIGHT) begin
         if (mirror_count == CNT_W'(DEPTH)) begin
            r.status = STATUS_OVERFLOW;
         end else if (k == KIND_PUSH_LEFT) begin
            left_pos = left_pos - 4'd1;
            mirror_words[left_pos] = w;
            mirror_count = mirror_count + CNT_W'(1);
         end else begin
            mirror_words[right_pos] = w;
            right_pos = right_pos + 4'd1;
            mirror_count = mirror_count + CNT_W'(1);
         end
      end else begin
         if (mirror_count == '0) begin
            r.status = STATUS_UNDERFLOW;
         end else if (k == KIND_POP_LEFT) begin
            r.popped = mirror_words[left_pos];
            left_pos = left_pos + 4'd1;
            mirror_count = mirror_count - CNT_W'(1);
         end else begin
            right_pos = right_pos - 4'd1;
            r.popped = mirror_words[right_pos];
            mirror_count = mirror_count - CNT_W'(1);
         end
      end
      r.occupancy = mirror_count;
   endtask

   task automatic report_mismatch(input logic orphan, input deque_result_type want,
                                  input deque_result_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         if (orphan)
            $display("%0t: result with nothing pending: popped %h status %0d occupancy %0d",
                     $realtime, got.popped, got.status, got.occupancy);
         else
            $display("%0t: mismatch: expected popped %h status %0d occupancy %0d, got %h %0d %0d",
                     $realtime, want.popped, want.status, want.occupancy,
                     got.popped, got.status, got.occupancy);
      end
   endtask

   // predict on every request transaction, check every response transaction
   always @(posedge clock) begin : monitor
      deque_result_type want;
      deque_result_type got;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_deque_op(kind_type'(req_tuser), req_tdata, want);
            if (fixed_on)
               want = fixed_result;
            pending_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_count++;
            got.popped    = rsp_tdata[WORD_W-1:0];
            got.status    = status_type'(rsp_tuser);
            got.occupancy = rsp_tdata[WORD_W +: CNT_W];
            if (pending_results.size() == 0) begin
               report_mismatch(1'b1, '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got.popped !== want.popped || got.status !== want.status ||
                   got.occupancy !== want.occupancy)
                  report_mismatch(1'b0, want, got);
            end
         end
      end
   end

   // receiver: switches at random between steady, sparse, bursty and coin-flip ready modes
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(50, 400);
      end
      rx_mode_left--;
      case (rx_mode)
         RX_STEADY: rsp_tready <= 1'b1;
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_BURSTY: begin
            if (rx_stall != 0) begin
               rx_stall--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 5) == 0)
                  rx_stall = $urandom_range(1, 12);
            end
         end
         default: rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic kind_type pick_push();
      return ($urandom_range(0, 1) != 0) ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT;
   endfunction

   function automatic kind_type pick_pop();
      return ($urandom_range(0, 1) != 0) ? KIND_POP_RIGHT : KIND_POP_LEFT;
   endfunction

   task automatic add_row(input kind_type k, input logic [WORD_W-1:0] w, input logic typed,
                          input logic [WORD_W-1:0] p, input status_type s,
                          input logic [CNT_W-1:0] o);
      op_row_type row;
      row.kind           = k;
      row.word           = w;
      row.typed          = typed;
      row.want.popped    = p;
      row.want.status    = s;
      row.want.occupancy = o;
      directed_rows.push_back(row);
   endtask

   // sender works in bursts; a gap drops tvalid for a while before the next burst
   task automatic issue_op(input kind_type k, input logic [WORD_W-1:0] w, input logic typed,
                           input deque_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid   <= 1'b1;
      req_tuser    <= k;
      req_tdata    <= w;
      fixed_on     <= typed;
      fixed_result <= want;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (k == KIND_PUSH_LEFT || k == KIND_PUSH_RIGHT) begin
         if (plan_count < DEPTH) plan_count++;
      end else if (plan_count > 0) begin
         plan_count--;
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (got_count < sent_count) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned pick;
      int          len;
      int          push_pct;
      kind_type    k;
      op_seq_type  seq;

      // empty deque, extremes at both ends, fill to full, overflow at both ends, then a pop right from full
      add_row(KIND_POP_LEFT,   32'h0,         1'b1, 32'h0, STATUS_UNDERFLOW, 5'd0);
      add_row(KIND_POP_RIGHT,  32'h1234_5678, 1'b1, 32'h0, STATUS_UNDERFLOW, 5'd0);
      add_row(KIND_PUSH_RIGHT, 32'h7fff_ffff, 1'b1, 32'h0, STATUS_OK,        5'd1);
      add_row(KIND_PUSH_LEFT,  32'h8000_0000, 1'b1, 32'h0, STATUS_OK,        5'd2);
      add_row(KIND_POP_RIGHT,  32'hffff_ffff, 1'b1, 32'h7fff_ffff, STATUS_OK, 5'd1);
      add_row(KIND_POP_LEFT,   32'h0,         1'b1, 32'h8000_0000, STATUS_OK, 5'd0);
      add_row(KIND_PUSH_LEFT,  32'hffff_ffff, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'h0000_0000, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_LEFT,  32'h0000_0001, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'hffff_fffe, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_LEFT,  32'h5555_5555, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'haaaa_aaaa, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_LEFT,  32'h7fff_ffff, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'h8000_0000, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_LEFT,  32'h0000_ffff, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'hffff_0000, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_LEFT,  32'h0123_4567, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'h89ab_cdef, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_LEFT,  32'h0f0f_0f0f, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'hf0f0_f0f0, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_LEFT,  32'h3333_3333, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'hcccc_cccc, 1'b0, '0, STATUS_OK, '0);
      add_row(KIND_PUSH_RIGHT, 32'h1111_1111, 1'b1, 32'h0, STATUS_OVERFLOW, 5'd16);
      add_row(KIND_PUSH_LEFT,  32'heeee_eeee, 1'b1, 32'h0, STATUS_OVERFLOW, 5'd16);
      add_row(KIND_POP_RIGHT,  32'h0,         1'b0, '0, STATUS_OK, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_op(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].typed,
                  directed_rows[i].want);
      wait_for_results();

      while (sent_count < directed_rows.size() + RANDOM_OPS) begin
         if ($urandom_range(0, 19) == 0)
            wait_for_results();
         pick = $urandom_range(0, 9);
         if (pick < 2)      seq = SEQ_FILL;
         else if (pick < 4) seq = SEQ_DRAIN;
         else if (pick < 9) seq = SEQ_MIXED;
         else               seq = SEQ_ANY;
         case (seq)
            SEQ_FILL: begin
               while (plan_count < DEPTH)
                  issue_op(pick_push(), pick_word(), 1'b0, '0);
               repeat ($urandom_range(1, 2)) issue_op(pick_push(), pick_word(), 1'b0, '0);
            end
            SEQ_DRAIN: begin
               while (plan_count > 0)
                  issue_op(pick_pop(), pick_word(), 1'b0, '0);
               repeat ($urandom_range(1, 2)) issue_op(pick_pop(), pick_word(), 1'b0, '0);
            end
            SEQ_MIXED: begin
               len      = $urandom_range(8, 40);
               push_pct = $urandom_range(25, 75);
               repeat (len) begin
                  k = ($urandom_range(0, 99) < push_pct) ? pick_push() : pick_pop();
                  issue_op(k, pick_word(), 1'b0, '0);
               end
            end
            default: begin
               repeat ($urandom_range(5, 20))
                  issue_op(kind_type'($urandom_range(0, 3)), $urandom, 1'b0, '0);
            end
         endcase
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
